// ===== rtl/ozc_pkg.sv =====
// ----------------------------------------------------------------------------
// ozc_pkg
// Shared widths, constants and the pressure correction table for the ozone
// concentration pipeline.
// ----------------------------------------------------------------------------
package ozc_pkg;

  localparam int P_W     = 17;
  localparam int RT_W    = 16;
  localparam int CUR_W   = 20;
  localparam int FLOW_W  = 8;
  localparam int TEMP_W  = 19;
  localparam int FAC_W   = 11;
  localparam int GAIN_W  = 13;
  localparam int SCALE_W = 30;
  localparam int LEFT_W  = CUR_W + TEMP_W;     // 39
  localparam int FR_W    = FAC_W + FLOW_W;     // 19
  localparam int RIGHT_W = 31;
  localparam int NUM_W   = LEFT_W + RIGHT_W;   // 70
  localparam int DEN_W   = P_W + SCALE_W;      // 47
  localparam int Q_W     = 32;
  localparam int TAB_LEN = 12;

  localparam logic [TEMP_W-1:0]  TEMP_ZERO_MK = 19'd273150;
  localparam logic [GAIN_W-1:0]  GAIN         = 13'd4307;
  localparam logic [SCALE_W-1:0] SCALE        = 30'd1000000000;
  localparam logic [FLOW_W-1:0]  FLOW_RESET   = 8'd30;
  localparam logic [FAC_W-1:0]   FAC_DEFAULT  = 11'd1000;

  localparam logic [P_W-1:0] CF_LIMIT [TAB_LEN] = '{
    17'd300, 17'd500, 17'd700, 17'd1000, 17'd1500, 17'd2000,
    17'd3000, 17'd5000, 17'd7000, 17'd10000, 17'd15000, 17'd20000
  };
  localparam logic [FAC_W-1:0] CF_MILLI [TAB_LEN] = '{
    11'd1240, 11'd1124, 11'd1087, 11'd1066, 11'd1048, 11'd1041,
    11'd1029, 11'd1018, 11'd1013, 11'd1007, 11'd1002, 11'd1000
  };

  typedef struct packed {
    logic sat;
    logic zero;
  } ozc_flags_t;

  // first threshold that the pressure lies below picks the factor
  function automatic logic [FAC_W-1:0] corr_factor(input logic [P_W-1:0] p);
    logic [FAC_W-1:0] f;
    logic             hit;
    f   = FAC_DEFAULT;
    hit = 1'b0;
    for (int i = 0; i < TAB_LEN; i++) begin
      if (!hit && p < CF_LIMIT[i]) begin
        f   = CF_MILLI[i];
        hit = 1'b1;
      end
    end
    return f;
  endfunction

endpackage

// ===== rtl/ozc_div.sv =====
// ----------------------------------------------------------------------------
// ozc_div
// Range check plus a restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module ozc_div import ozc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic             zero,
  output logic             out_valid,
  output logic [Q_W-1:0]   quot,
  output ozc_flags_t       flags
);

  logic             vld  [Q_W+1];
  logic [DEN_W-1:0] rem  [Q_W+1];
  logic [Q_W-1:0]   nlo  [Q_W+1];
  logic [Q_W-1:0]   q    [Q_W+1];
  logic [DEN_W-1:0] d    [Q_W+1];
  ozc_flags_t       fl   [Q_W+1];

  logic             sat_in;

  // quotient reaches 2^32 exactly when the upper numerator bits reach d
  assign sat_in = {{(DEN_W-(NUM_W-Q_W)){1'b0}}, num[NUM_W-1:Q_W]} >= den;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]     <= {{(DEN_W-(NUM_W-Q_W)){1'b0}}, num[NUM_W-1:Q_W]};
      nlo[0]     <= num[Q_W-1:0];
      q[0]       <= '0;
      d[0]       <= den;
      fl[0].sat  <= sat_in;
      fl[0].zero <= zero;
    end
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    logic [DEN_W:0] t;
    logic [DEN_W:0] diff;
    logic           ge;

    assign t    = {rem[i], nlo[i][Q_W-1]};
    assign diff = t - {1'b0, d[i]};
    assign ge   = t >= {1'b0, d[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        nlo[i+1] <= {nlo[i][Q_W-2:0], 1'b0};
        q[i+1]   <= {q[i][Q_W-2:0], ge};
        d[i+1]   <= d[i];
        fl[i+1]  <= fl[i];
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign quot      = q[Q_W];
  assign flags     = fl[Q_W];

endmodule

// ===== rtl/ozone_concentration_calc_top.sv =====
// ----------------------------------------------------------------------------
// ozone_concentration_calc_top
// Ozone in 0.001 ppb from pressure, pump temperature and cell current.
//
//   channel  | direction | handshake               | payload
//   s_axis   | in        | s_axis_tvalid / tready  | tdata: pressure, temp, current
//   m_axis   | out       | m_axis_tvalid / tready  | tdata: ozone; tuser: sat, zero
//   cfg      | in        | cfg_valid / cfg_ready   | cfg_data: pump flow seconds
//
// one word accepted per cycle while the pipeline is not held; the pipeline is the 5
// front-end stages, one range check stage and 32 one-bit divide stages
// rst clears all valid bits and loads pump flow seconds with 30
// the whole pipeline holds while the output word waits and m_axis_tready is low
// ----------------------------------------------------------------------------
module ozone_concentration_calc_top import ozc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // pressure_centi_hpa, raw_pump_temp, raw_cell_current
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // ozone_milli_ppb
  output logic [1:0]  m_axis_tuser,   // saturated, zero_pressure
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data        // pump_flow_seconds
);

  logic              adv;
  logic [FLOW_W-1:0] flow;

  logic [P_W-1:0]    in_p;
  logic [RT_W-1:0]   in_rt;
  logic [CUR_W-1:0]  in_cur;

  logic              v1, v2, v3, v4, v5;
  logic [P_W-1:0]    p1;
  logic [TEMP_W-1:0] temp1;
  logic [CUR_W-1:0]  cur1;
  logic [FAC_W-1:0]  fac1;
  logic              zero1, zero2, zero3, zero4, zero5;
  logic [LEFT_W-1:0] left2, left3;
  logic [FR_W-1:0]   fr2;
  logic [DEN_W-1:0]  d2, d3, d4, d5;
  logic [31:0]       right_full;
  logic [RIGHT_W-1:0] right3;
  logic [Q_W+RIGHT_W-1:0] plo4;
  logic [LEFT_W-Q_W+RIGHT_W-1:0] phi4;
  logic [NUM_W-1:0]  num5;

  logic              dv;
  logic [Q_W-1:0]    quot;
  ozc_flags_t        flags;

  assign in_p   = s_axis_tdata[16:0];
  assign in_rt  = s_axis_tdata[32:17];
  assign in_cur = s_axis_tdata[52:33];

  assign adv           = !dv || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flow <= FLOW_RESET;
    end else if (cfg_valid) begin
      flow <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  assign right_full = {13'b0, fr2} * {19'b0, GAIN};

  always_ff @(posedge clk) begin
    if (adv) begin
      // temperature, correction factor
      p1    <= in_p;
      cur1  <= in_cur;
      temp1 <= in_rt[RT_W-1] ? TEMP_ZERO_MK - {4'b0, in_rt[RT_W-2:0]}
                             : TEMP_ZERO_MK + {4'b0, in_rt[RT_W-2:0]};
      fac1  <= corr_factor(in_p);
      zero1 <= in_p == '0;
      // current times temperature, factor times flow, divisor
      left2 <= {19'b0, cur1} * {20'b0, temp1};
      fr2   <= {8'b0, fac1} * {11'b0, flow};
      d2    <= {30'b0, p1} * {17'b0, SCALE};
      zero2 <= zero1;
      // gain
      left3  <= left2;
      right3 <= right_full[RIGHT_W-1:0];
      d3     <= d2;
      zero3  <= zero2;
      // partial products
      plo4  <= {31'b0, left3[Q_W-1:0]} * {32'b0, right3};
      phi4  <= {31'b0, left3[LEFT_W-1:Q_W]} * {7'b0, right3};
      d4    <= d3;
      zero4 <= zero3;
      // full numerator
      num5  <= {7'b0, plo4} + {phi4, 32'b0};
      d5    <= d4;
      zero5 <= zero4;
    end
  end

  ozc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v5),
    .num       (num5),
    .den       (d5),
    .zero      (zero5),
    .out_valid (dv),
    .quot      (quot),
    .flags     (flags)
  );

  assign m_axis_tvalid   = dv;
  assign m_axis_tdata    = flags.zero ? '0 : (flags.sat ? '1 : quot);
  assign m_axis_tuser[0] = flags.sat && !flags.zero;
  assign m_axis_tuser[1] = flags.zero;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && in_p == '0) |=> zero1)
    else $error("zero pressure not flagged in first stage");

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0 && !m_axis_tuser[0]))
    else $error("zero pressure word not cleared");

  a_sat_out: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tdata == '1)
    else $error("saturated word not at maximum");

endmodule

// ===== tb/sv/ozone_concentration_calc_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ozone_concentration_calc_top_tb
// Self-checking bench for the ozone concentration pipeline. Readings are fed
// from a queue on the input stream with random gaps while the output side
// stalls at random. Every accepted reading is predicted in exact wide integer
// math and matched against the next output word. The pump flow register is
// rewritten between phases, each time after the pipeline has drained.
// ----------------------------------------------------------------------------
module ozone_concentration_calc_top_tb;

  localparam int TAB_LEN        = 12;
  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PH   = 225;
  localparam int MAX_GAP        = 16;
  localparam int DRAIN_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [18:0]  ZERO_C_MK  = 19'd273150;
  localparam logic [12:0]  CELL_GAIN  = 13'd4307;
  localparam logic [29:0]  DEN_SCALE  = 30'd1000000000;
  localparam logic [31:0]  OZONE_MAX  = 32'hFFFFFFFF;

  localparam logic [16:0] PRESS_EDGE [TAB_LEN] = '{
    17'd300, 17'd500, 17'd700, 17'd1000, 17'd1500, 17'd2000,
    17'd3000, 17'd5000, 17'd7000, 17'd10000, 17'd15000, 17'd20000
  };
  localparam logic [10:0] PRESS_CORR [TAB_LEN] = '{
    11'd1240, 11'd1124, 11'd1087, 11'd1066, 11'd1048, 11'd1041,
    11'd1029, 11'd1018, 11'd1013, 11'd1007, 11'd1002, 11'd1000
  };

  typedef struct packed {
    logic [31:0] ozone;
    logic        sat;
    logic        zero_p;
  } ozone_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  logic [55:0] reading_q [$];
  ozone_word_t ozone_expect_q [$];
  logic [7:0]  flow_seconds = 8'd30;
  int          in_max_gap = 0;
  int          out_max_gap = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          err_count = 0;
  int          idle_cycles = 0;

  ozone_concentration_calc_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [10:0] pressure_corr(input logic [16:0] p);
    logic [10:0] f;
    logic        hit;
    f   = 11'd1000;
    hit = 1'b0;
    for (int i = 0; i < TAB_LEN; i++) begin
      if (!hit && p < PRESS_EDGE[i]) begin
        f   = PRESS_CORR[i];
        hit = 1'b1;
      end
    end
    return f;
  endfunction

  function automatic ozone_word_t ozone_from_reading(input logic [55:0] w,
                                                     input logic [7:0] flow);
    logic [16:0]  p;
    logic [15:0]  rt;
    logic [19:0]  cur;
    logic [18:0]  temp_mk;
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    ozone_word_t  r;
    p   = w[16:0];
    rt  = w[32:17];
    cur = w[52:33];
    r   = '0;
    if (p == '0) begin
      r.zero_p = 1'b1;
    end else begin
      temp_mk = rt[15] ? ZERO_C_MK - 19'(rt[14:0]) : ZERO_C_MK + 19'(rt[14:0]);
      num = 128'(cur) * 128'(temp_mk) * 128'(CELL_GAIN) * 128'(flow)
          * 128'(pressure_corr(p));
      den = 128'(p) * 128'(DEN_SCALE);
      q   = num / den;
      if (q > 128'(OZONE_MAX)) begin
        r.ozone = OZONE_MAX;
        r.sat   = 1'b1;
      end else begin
        r.ozone = q[31:0];
      end
    end
    return r;
  endfunction

  function automatic logic [55:0] pack_reading(input logic [16:0] p, input logic [15:0] rt,
                                               input logic [19:0] cur);
    return {3'b000, cur, rt, p};
  endfunction

  function automatic logic [55:0] random_reading();
    int          sel;
    logic [16:0] p;
    logic [15:0] rt;
    logic [19:0] cur;
    sel = $urandom_range(0, 99);
    if (sel < 5) p = '0;
    else if (sel < 30) p = PRESS_EDGE[$urandom_range(0, TAB_LEN-1)] - 17'($urandom_range(0, 1));
    else if (sel < 40) p = 17'($urandom_range(1, 40));
    else if (sel < 50) p = 17'($urandom_range(1, 300));
    else p = 17'($urandom);
    sel = $urandom_range(0, 99);
    case (sel % 4)
      0: rt = 16'h0000;
      1: rt = 16'h7FFF;
      2: rt = 16'h8000;
      default: rt = 16'hFFFF;
    endcase
    if (sel >= 10) rt = 16'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 5) cur = '0;
    else if (sel < 10) cur = 20'hFFFFF;
    else cur = 20'($urandom);
    return pack_reading(p, rt, cur);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      in_gap        <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        ozone_expect_q.push_back(ozone_from_reading(s_axis_tdata, flow_seconds));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (in_gap != 0) begin
          s_axis_tvalid <= 1'b0;
          in_gap        <= in_gap - 1;
        end else if (reading_q.size() > 0) begin
          s_axis_tdata  <= reading_q.pop_front();
          s_axis_tvalid <= 1'b1;
          in_gap        <= (in_max_gap > 0) ? $urandom_range(0, in_max_gap) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    ozone_word_t exp_w;
    int          nxt;
    if (rst) begin
      m_axis_tready <= 1'b0;
      out_gap       <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (ozone_expect_q.size() == 0) begin
        err_count = err_count + 1;
        if (err_count <= 10)
          $display("unexpected word: ozone %0d sat %0b zero %0b",
                   m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
      end else begin
        exp_w = ozone_expect_q.pop_front();
        if (m_axis_tdata !== exp_w.ozone || m_axis_tuser[0] !== exp_w.sat ||
            m_axis_tuser[1] !== exp_w.zero_p) begin
          err_count = err_count + 1;
          if (err_count <= 10)
            $display("mismatch: ozone exp %0d got %0d, sat exp %0b got %0b, zero exp %0b got %0b",
                     exp_w.ozone, m_axis_tdata, exp_w.sat, m_axis_tuser[0],
                     exp_w.zero_p, m_axis_tuser[1]);
        end
      end
      nxt = (out_max_gap > 0) ? $urandom_range(0, out_max_gap) : 0;
      out_gap       <= nxt;
      m_axis_tready <= (nxt == 0);
    end else if (out_gap != 0) begin
      out_gap       <= out_gap - 1;
      m_axis_tready <= (out_gap == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_flow(input logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    flow_seconds = v;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (reading_q.size() != 0 || s_axis_tvalid || ozone_expect_q.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    logic [7:0] flow_plan [PHASES];
    flow_plan = '{8'd30, 8'd255, 8'd1, 8'd0, 8'd0, 8'd0, 8'd30, 8'd0};
    flow_plan[4] = 8'($urandom_range(2, 254));
    flow_plan[5] = 8'($urandom_range(2, 254));
    flow_plan[7] = 8'($urandom_range(1, 255));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed readings at the reset flow value
    @(negedge clk);
    in_max_gap  = 0;
    out_max_gap = 0;
    reading_q.push_back(pack_reading(17'd0, 16'h1234, 20'hABCDE));
    reading_q.push_back(pack_reading(17'd0, 16'hFFFF, 20'hFFFFF));
    reading_q.push_back(pack_reading(17'd1, 16'h7FFF, 20'hFFFFF));
    reading_q.push_back(pack_reading(17'd1, 16'h0000, 20'd1));
    reading_q.push_back(pack_reading(17'd1, 16'h8000, 20'd0));
    reading_q.push_back(pack_reading(17'h1FFFF, 16'h7FFF, 20'hFFFFF));
    reading_q.push_back(pack_reading(17'h1FFFF, 16'hFFFF, 20'd1));
    reading_q.push_back(pack_reading(17'h1FFFF, 16'h0000, 20'd0));
    reading_q.push_back(pack_reading(17'd299, 16'h8000, 20'h80000));
    reading_q.push_back(pack_reading(17'd300, 16'h0000, 20'h80000));
    reading_q.push_back(pack_reading(17'd999, 16'hFFFF, 20'h7FFFF));
    reading_q.push_back(pack_reading(17'd1000, 16'h7FFF, 20'h7FFFF));
    reading_q.push_back(pack_reading(17'd19999, 16'h4000, 20'h55555));
    reading_q.push_back(pack_reading(17'd20000, 16'hC000, 20'hAAAAA));
    reading_q.push_back(pack_reading(17'd2, 16'h8000, 20'hFFFFF));
    reading_q.push_back(pack_reading(17'd3, 16'h8001, 20'h12345));
    reading_q.push_back(pack_reading(17'd40, 16'h0001, 20'hFFFFF));
    reading_q.push_back(pack_reading(17'h15555, 16'h5555, 20'h55555));
    reading_q.push_back(pack_reading(17'h0AAAA, 16'hAAAA, 20'hAAAAA));
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) write_flow(flow_plan[ph]);
      @(negedge clk);
      in_max_gap  = (ph % 3 == 0) ? 0 : MAX_GAP;
      out_max_gap = (ph % 4 == 1 || ph == 0) ? 0 : MAX_GAP;
      for (int i = 0; i < ITEMS_PER_PH; i++)
        reading_q.push_back(random_reading());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && ozone_expect_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== ozone_concentration_calc_top.f =====
rtl/ozc_pkg.sv
rtl/ozc_div.sv
rtl/ozone_concentration_calc_top.sv
tb/sv/ozone_concentration_calc_top_tb.sv
